// ----- rtl/sspl_pkg.sv -----
// shared types and constants for the stable sorted priority list
`default_nettype none
package sspl_pkg;

  localparam int CAPACITY      = 32;
  localparam int PRIORITY_BITS = 8;
  localparam int ID_W          = 16;
  localparam int AW            = $clog2(CAPACITY);
  localparam int CW            = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_REMOVE_AT = 2'd1,
    OP_REMOVE_ID = 2'd2,
    OP_READ_AT   = 2'd3
  } sspl_op_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } sspl_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_FIND_RD,
    S_FIND_CMP,
    S_POS_RD,
    S_POS_CAP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } sspl_state_t;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic [PRIORITY_BITS-1:0] prio;
  } sspl_slot_t;

  typedef struct packed {
    logic            we;
    logic [AW-1:0]   waddr;
    sspl_slot_t      wdata;
    logic [AW-1:0]   raddr;
  } sspl_mem_req_t;

  typedef struct packed {
    sspl_status_t             status;
    logic [ID_W-1:0]          rid;
    logic [PRIORITY_BITS-1:0] rprio;
    logic [CW-1:0]            count;
  } sspl_result_t;

endpackage
`default_nettype wire

// ----- rtl/sspl_slot_ram.sv -----
// slot store: one write port and one registered read port
`default_nettype none
module sspl_slot_ram
  import sspl_pkg::*;
(
  input  wire logic          clk,
  input  wire sspl_mem_req_t req,
  output sspl_slot_t         rdata_r
);

  sspl_slot_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/sspl_seq.sv -----
// sequencer: walks the slot store one slot at a time
`default_nettype none
module sspl_seq
  import sspl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire sspl_op_t                 op,
  input  wire logic [ID_W-1:0]          entry_id,
  input  wire logic [PRIORITY_BITS-1:0] entry_priority,
  input  wire logic [4:0]               position,
  input  wire sspl_slot_t               rdata,
  output sspl_mem_req_t                 mem_req,
  output logic                          busy,
  output logic                          done,
  output sspl_result_t                  result
);

  sspl_state_t              state_r, state_nxt;
  sspl_op_t                 op_r, op_nxt;
  logic [ID_W-1:0]          id_r, id_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  sspl_status_t             status_r, status_nxt;
  logic [ID_W-1:0]          rid_r, rid_nxt;
  logic [PRIORITY_BITS-1:0] rprio_r, rprio_nxt;
  logic [CW-1:0]            idx_inc, idx_dec, pos_ext;
  logic                     accept;

  assign idx_inc = idx_r + CW'(1);
  assign idx_dec = idx_r - CW'(1);
  assign pos_ext = CW'(position);
  assign accept  = start && (state_r == S_IDLE);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // operands and result fields
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    prio_r   <= prio_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    rid_r    <= rid_nxt;
    rprio_r  <= rprio_nxt;
  end

  // next state and slot store requests
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    prio_nxt      = prio_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    rid_nxt       = rid_r;
    rprio_nxt     = rprio_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r[AW-1:0];
    mem_req.wdata = rdata;
    mem_req.raddr = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = op;
          id_nxt     = entry_id;
          prio_nxt   = entry_priority;
          status_nxt = STAT_DONE;
          rid_nxt    = '0;
          rprio_nxt  = '0;
          case (op)
            OP_INSERT: begin
              idx_nxt = count_r;
              if (count_r == CW'(CAPACITY)) begin
                status_nxt = STAT_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            OP_REMOVE_ID: begin
              idx_nxt   = '0;
              state_nxt = S_FIND_RD;
            end
            default: begin
              idx_nxt = pos_ext;
              if (pos_ext >= count_r) begin
                status_nxt = STAT_NOT_FOUND;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_POS_RD;
              end
            end
          endcase
        end
      end

      // insert: walk from the tail towards the head
      S_INS_RD: begin
        if (idx_r == '0) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = '{id: id_r, prio: prio_r};
          count_nxt     = count_r + CW'(1);
          state_nxt     = S_DONE;
        end else begin
          mem_req.raddr = idx_dec[AW-1:0];
          state_nxt     = S_INS_CMP;
        end
      end

      // equal or higher priority stays ahead of the new entry
      S_INS_CMP: begin
        mem_req.we = 1'b1;
        if (rdata.prio >= prio_r) begin
          mem_req.wdata = '{id: id_r, prio: prio_r};
          count_nxt     = count_r + CW'(1);
          state_nxt     = S_DONE;
        end else begin
          idx_nxt   = idx_dec;
          state_nxt = S_INS_RD;
        end
      end

      // remove by id: scan from the head
      S_FIND_RD: begin
        if (idx_r >= count_r) begin
          status_nxt = STAT_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_FIND_CMP;
        end
      end

      S_FIND_CMP: begin
        if (rdata.id == id_r) begin
          rid_nxt   = rdata.id;
          rprio_nxt = rdata.prio;
          state_nxt = S_SHIFT_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_FIND_RD;
        end
      end

      // positional access
      S_POS_RD: begin
        state_nxt = S_POS_CAP;
      end

      S_POS_CAP: begin
        rid_nxt   = rdata.id;
        rprio_nxt = rdata.prio;
        state_nxt = (op_r == OP_READ_AT) ? S_DONE : S_SHIFT_RD;
      end

      // close the gap: move each later slot one place towards the head
      S_SHIFT_RD: begin
        if (idx_inc >= count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_req.raddr = idx_inc[AW-1:0];
          state_nxt     = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        mem_req.we = 1'b1;
        idx_nxt    = idx_inc;
        state_nxt  = S_SHIFT_RD;
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != S_IDLE);
  assign done          = (state_r == S_DONE);
  assign result.status = status_r;
  assign result.rid    = rid_r;
  assign result.rprio  = rprio_r;
  assign result.count  = count_r;

endmodule
`default_nettype wire

// ----- rtl/stable_sorted_priority_list.sv -----
// Top level: sorted list of id/priority entries, one slot store walked by a sequencer.
// A full insert or a position not held ends at once; a read reads and captures its slot;
// remove by id scans from the head (hit or miss), shifting on a hit; remove at position
// captures, then shifts; insert compares from the tail, moving lower entries back.
// Next request is taken at the edge ending the result cycle; results cannot stall.
// Synchronous active-low reset empties the list; slot contents are not cleared.
`default_nettype none
module stable_sorted_priority_list
  import sspl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               in_op,
  input  wire logic [15:0]              in_entry_id,
  input  wire logic [7:0]               in_entry_priority,
  input  wire logic [4:0]               in_position,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [15:0]                   out_result_id,
  output logic [7:0]                    out_result_priority,
  output logic [5:0]                    out_entry_count
);

  sspl_mem_req_t mem_req;
  sspl_slot_t    rdata;
  sspl_result_t  result;
  logic          done;
  logic          valid_r;
  sspl_result_t  res_r;

  sspl_slot_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rdata_r (rdata)
  );

  sspl_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .op             (sspl_op_t'(in_op)),
    .entry_id       (in_entry_id),
    .entry_priority (in_entry_priority[PRIORITY_BITS-1:0]),
    .position       (in_position),
    .rdata          (rdata),
    .mem_req        (mem_req),
    .busy           (busy),
    .done           (done),
    .result         (result)
  );

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= done;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= result;
    end
  end

  assign out_valid           = valid_r;
  assign out_status          = res_r.status;
  assign out_result_id       = res_r.rid;
  assign out_result_priority = 8'(res_r.rprio);
  assign out_entry_count     = 6'(res_r.count);

endmodule
`default_nettype wire
